// ----- rtl/rwp_pkg.sv -----
// shared types and constants for the riff/wave pcm16 stream parser
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package rwp_pkg;

	// file header layout
	localparam int HDR_LEN = 12;
	localparam logic [7:0] MAGIC_RIFF [4] = '{8'h52, 8'h49, 8'h46, 8'h46};
	localparam logic [7:0] MAGIC_WAVE [4] = '{8'h57, 8'h41, 8'h56, 8'h45};

	// chunk ids, first id byte in the top bits
	localparam logic [31:0] ID_FMT  = 32'h666D7420;
	localparam logic [31:0] ID_DATA = 32'h64617461;

	// fmt chunk byte positions, counted from the first id byte
	localparam int FMT_CH_LO   = 10;
	localparam int FMT_CH_HI   = 11;
	localparam int FMT_RATE_LO = 12;
	localparam int FMT_RATE_HI = 15;
	localparam int FMT_BITS_LO = 22;
	localparam int FMT_BITS_HI = 23;
	localparam int CHUNK_HDR   = 8;
	localparam int PCM_BITS    = 16;

	// report status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOT_WAVE = 2'd1;
	localparam logic [1:0] ST_NO_PCM16 = 2'd2;

	// result kinds
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	// output queue
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	localparam int TDATA_W = 104;

	typedef struct packed {
		logic               kind;
		logic signed [15:0] sample;
		logic [1:0]         status;
		logic [15:0]        channel_count;
		logic [31:0]        sample_rate;
		logic [30:0]        sample_total;
		logic               last;
	} item_t;

	// up to two results from one byte: a sample, then the report
	typedef struct packed {
		logic  smp_vld;
		logic  rpt_vld;
		item_t smp;
		item_t rpt;
	} bundle_t;

endpackage

// ----- rtl/riff_wav_pcm16_stream_parser.sv -----
// top level of the riff/wave pcm16 stream parser
// depends on rwp_pkg, rwp_parser and rwp_outq
`timescale 1ns / 1ps

// channel   dir  tdata                         tuser   tlast
// s_axis    in   data_byte[7:0]                -       end_of_file
// m_axis    out  sample, status, channel_count  kind    last
//                sample_rate, sample_total
//
// one file byte is taken every cycle while s_tready is high; the parser updates
// its chunk state and registers its results, and a 4-item output queue then
// registers them and shows them on the master side
// the final byte of a file that also completes a sample gives two items, which
// the queue takes in together and hands out one after the other
// s_tready falls when the queue, counting results still in the parser
// register, cannot take two more items; a stalled master never loses items
// arst_n clears the parser state, the result valids and the queue pointers

module riff_wav_pcm16_stream_parser
	import rwp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] data_byte
	input  logic               s_tlast,   // end_of_file
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // [15:0] sample, [17:16] status,
	                                      // [33:18] channel_count,
	                                      // [65:34] sample_rate,
	                                      // [96:66] sample_total, rest zero
	output logic               m_tuser,   // [0] kind
	output logic               m_tlast    // last
);

	bundle_t bundle;
	logic    room;
	item_t   head;

	// chunk walk and result register
	rwp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (s_tvalid),
		.in_byte (s_tdata),
		.in_eof  (s_tlast),
		.room    (room),
		.in_rdy  (s_tready),
		.bundle  (bundle)
	);

	// decouples the master side from the byte stream
	rwp_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.bundle   (bundle),
		.out_rdy  (m_tready),
		.out_vld  (m_tvalid),
		.out_item (head),
		.room     (room)
	);

	// pack fields from the lowest bit up, zero pad to whole bytes
	assign m_tdata = {7'd0, head.sample_total, head.sample_rate, head.channel_count,
		head.status, head.sample};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

endmodule

// ----- rtl/rwp_parser.sv -----
// byte parser: header check, chunk walk, fmt capture, sample pairing
// depends on rwp_pkg; registers its results into a bundle for rwp_outq
`timescale 1ns / 1ps

module rwp_parser
	import rwp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_vld,
	input  logic [7:0] in_byte,
	input  logic       in_eof,
	input  logic       room,
	output logic       in_rdy,
	output bundle_t    bundle
);

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_CHUNKS = 2'd1;
	localparam logic [1:0] PH_IGNORE = 2'd2;

	logic [3:0]  hdr_cnt_q, hdr_cnt_n;
	logic        hdr_bad_q, hdr_bad_n;
	logic [1:0]  phase_q, phase_n;
	logic [31:0] chunk_id_q, chunk_id_n;
	logic [31:0] chunk_len_q, chunk_len_n;
	logic [32:0] chunk_pos_q, chunk_pos_n;
	logic [15:0] fmt_ch_q, fmt_ch_n;
	logic [31:0] fmt_rate_q, fmt_rate_n;
	logic [15:0] fmt_bits_q, fmt_bits_n;
	logic        data_seen_q, data_seen_n;
	logic [7:0]  low_hold_q, low_hold_n;
	logic [30:0] smp_cnt_q, smp_cnt_n;

	logic        smp_vld_s1, rpt_vld_s1;
	item_t       smp_s1, rpt_s1;

	logic        accept;
	logic        smp_hit;
	item_t       smp_item, rpt_item;
	logic        in_body;
	logic [32:0] body_lim, pos_inc, wrap_lim;
	logic [1:0]  st;

	assign in_rdy = room;
	assign accept = in_vld & room;

	always_comb begin
		hdr_cnt_n   = hdr_cnt_q;
		hdr_bad_n   = hdr_bad_q;
		phase_n     = phase_q;
		chunk_id_n  = chunk_id_q;
		chunk_len_n = chunk_len_q;
		chunk_pos_n = chunk_pos_q;
		fmt_ch_n    = fmt_ch_q;
		fmt_rate_n  = fmt_rate_q;
		fmt_bits_n  = fmt_bits_q;
		data_seen_n = data_seen_q;
		low_hold_n  = low_hold_q;
		smp_cnt_n   = smp_cnt_q;
		smp_hit     = 1'b0;
		st          = ST_OK;
		body_lim    = {1'b0, chunk_len_q} + 33'(CHUNK_HDR);
		in_body     = (chunk_pos_q >= 33'(CHUNK_HDR)) && (chunk_pos_q < body_lim);
		pos_inc     = chunk_pos_q + 33'd1;
		wrap_lim    = '0;

		smp_item               = '0;
		smp_item.kind          = KIND_SAMPLE;
		smp_item.sample        = {in_byte, low_hold_q};
		rpt_item               = '0;

		if (accept) begin
			unique case (phase_q)
				PH_HEADER: begin
					if (hdr_cnt_q < 4'd4 && in_byte != MAGIC_RIFF[hdr_cnt_q[1:0]])
						hdr_bad_n = 1'b1;
					if (hdr_cnt_q >= 4'd8 && in_byte != MAGIC_WAVE[hdr_cnt_q[1:0]])
						hdr_bad_n = 1'b1;
					if (hdr_bad_n) begin
						phase_n = PH_IGNORE;
					end else if (hdr_cnt_q == 4'(HDR_LEN - 1)) begin
						phase_n = PH_CHUNKS;
					end
				end
				PH_CHUNKS: begin
					if (chunk_pos_q < 33'd4) begin
						chunk_id_n = {chunk_id_q[23:0], in_byte};
					end else if (chunk_pos_q < 33'(CHUNK_HDR)) begin
						if (chunk_pos_q[1:0] == 2'd0) chunk_len_n = {24'd0, in_byte};
						else chunk_len_n[8*chunk_pos_q[1:0] +: 8] = in_byte;
						if (chunk_pos_q[1:0] == 2'd3 && chunk_id_q == ID_DATA)
							data_seen_n = 1'b1;
					end else if (in_body) begin
						if (chunk_id_q == ID_FMT) begin
							if (chunk_pos_q == 33'(FMT_CH_LO)) fmt_ch_n[7:0] = in_byte;
							else if (chunk_pos_q == 33'(FMT_CH_HI)) fmt_ch_n[15:8] = in_byte;
							else if (chunk_pos_q >= 33'(FMT_RATE_LO)
								&& chunk_pos_q <= 33'(FMT_RATE_HI))
								fmt_rate_n[8*chunk_pos_q[1:0] +: 8] = in_byte;
							else if (chunk_pos_q == 33'(FMT_BITS_LO)) fmt_bits_n[7:0] = in_byte;
							else if (chunk_pos_q == 33'(FMT_BITS_HI)) fmt_bits_n[15:8] = in_byte;
						end else if (chunk_id_q == ID_DATA) begin
							// body offset parity equals position parity
							if (!chunk_pos_q[0]) begin
								low_hold_n = in_byte;
							end else begin
								smp_hit = 1'b1;
								if (smp_cnt_q != '1) smp_cnt_n = smp_cnt_q + 31'd1;
							end
						end
					end
					// chunk ends after the body and the pad byte of an odd length
					wrap_lim = {1'b0, chunk_len_n} + 33'(CHUNK_HDR) + {32'd0, chunk_len_n[0]};
					if (pos_inc >= 33'(CHUNK_HDR) && pos_inc == wrap_lim) chunk_pos_n = '0;
					else chunk_pos_n = pos_inc;
				end
				default: ;
			endcase

			if (hdr_cnt_q != 4'(HDR_LEN)) hdr_cnt_n = hdr_cnt_q + 4'd1;

			if (in_eof) begin
				if (hdr_bad_n || hdr_cnt_n < 4'(HDR_LEN)) st = ST_NOT_WAVE;
				else if (!data_seen_n || fmt_bits_n != 16'(PCM_BITS)) st = ST_NO_PCM16;
				else st = ST_OK;
				rpt_item.kind          = KIND_REPORT;
				rpt_item.status        = st;
				rpt_item.channel_count = fmt_ch_n;
				rpt_item.sample_rate   = fmt_rate_n;
				rpt_item.sample_total  = smp_cnt_n;
				rpt_item.last          = 1'b1;
				// next byte starts a new file
				hdr_cnt_n   = '0;
				hdr_bad_n   = 1'b0;
				phase_n     = PH_HEADER;
				chunk_id_n  = '0;
				chunk_len_n = '0;
				chunk_pos_n = '0;
				fmt_ch_n    = '0;
				fmt_rate_n  = '0;
				fmt_bits_n  = '0;
				data_seen_n = 1'b0;
				low_hold_n  = '0;
				smp_cnt_n   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q   <= '0;
			hdr_bad_q   <= 1'b0;
			phase_q     <= PH_HEADER;
			chunk_id_q  <= '0;
			chunk_len_q <= '0;
			chunk_pos_q <= '0;
			fmt_ch_q    <= '0;
			fmt_rate_q  <= '0;
			fmt_bits_q  <= '0;
			data_seen_q <= 1'b0;
			low_hold_q  <= '0;
			smp_cnt_q   <= '0;
			smp_vld_s1  <= 1'b0;
			rpt_vld_s1  <= 1'b0;
		end else begin
			hdr_cnt_q   <= hdr_cnt_n;
			hdr_bad_q   <= hdr_bad_n;
			phase_q     <= phase_n;
			chunk_id_q  <= chunk_id_n;
			chunk_len_q <= chunk_len_n;
			chunk_pos_q <= chunk_pos_n;
			fmt_ch_q    <= fmt_ch_n;
			fmt_rate_q  <= fmt_rate_n;
			fmt_bits_q  <= fmt_bits_n;
			data_seen_q <= data_seen_n;
			low_hold_q  <= low_hold_n;
			smp_cnt_q   <= smp_cnt_n;
			smp_vld_s1  <= accept & smp_hit;
			rpt_vld_s1  <= accept & in_eof;
		end
	end

	always_ff @(posedge clk) begin
		smp_s1 <= smp_item;
		rpt_s1 <= rpt_item;
	end

	assign bundle = '{smp_vld: smp_vld_s1, rpt_vld: rpt_vld_s1, smp: smp_s1, rpt: rpt_s1};

`ifndef SYNTHESIS
	a_rpt_clears: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_vld_s1 |-> (phase_q == PH_HEADER && hdr_cnt_q == '0 && smp_cnt_q == '0))
		else $error("parser state not cleared after report");
	a_smp_phase: assert property (@(posedge clk) disable iff (!arst_n)
		smp_vld_s1 |-> $past(phase_q) == PH_CHUNKS)
		else $error("sample produced outside chunk walk");
	a_ignore_bad: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IGNORE |-> hdr_bad_q)
		else $error("ignore phase without bad header");
	a_hdr_sat: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_cnt_q <= 4'(HDR_LEN))
		else $error("header counter past saturation");
`endif

endmodule

// ----- rtl/rwp_outq.sv -----
// output queue: takes up to two results a cycle, hands out one item a cycle while out_rdy is high
// depends on rwp_pkg; fed by rwp_parser
`timescale 1ns / 1ps

module rwp_outq
	import rwp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  bundle_t bundle,
	input  logic    out_rdy,
	output logic    out_vld,
	output item_t   out_item,
	output logic    room
);

	item_t                 mem_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [OQ_CNT_W-1:0]   cnt_q;
	logic [OQ_CNT_W-1:0]   push_n;
	logic [OQ_PTR_W-1:0]   rpt_ptr;
	logic                  pop;

	assign push_n  = OQ_CNT_W'(bundle.smp_vld) + OQ_CNT_W'(bundle.rpt_vld);
	assign rpt_ptr = wr_ptr_q + OQ_PTR_W'(bundle.smp_vld);
	assign out_vld = (cnt_q != '0);
	assign out_item = mem_q[rd_ptr_q];
	assign pop     = out_vld & out_rdy;
	// space for two more items beyond what is queued or on its way
	assign room    = ((OQ_CNT_W+1)'(cnt_q) + (OQ_CNT_W+1)'(push_n))
		<= (OQ_CNT_W+1)'(OQ_DEPTH - 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OQ_PTR_W'(push_n);
			if (pop) rd_ptr_q <= rd_ptr_q + OQ_PTR_W'(1);
			cnt_q <= cnt_q + push_n - OQ_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (bundle.smp_vld) mem_q[wr_ptr_q] <= bundle.smp;
		if (bundle.rpt_vld) mem_q[rpt_ptr] <= bundle.rpt;
	end

`ifndef SYNTHESIS
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= OQ_CNT_W'(OQ_DEPTH))
		else $error("output queue count above depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		((OQ_CNT_W+1)'(cnt_q) + (OQ_CNT_W+1)'(push_n))
			<= ((OQ_CNT_W+1)'(OQ_DEPTH) + (OQ_CNT_W+1)'(pop)))
		else $error("output queue overflow");
	a_ptr_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_ptr_q == wr_ptr_q) |-> (cnt_q == '0 || cnt_q == OQ_CNT_W'(OQ_DEPTH)))
		else $error("queue pointers disagree with count");
`endif

endmodule
